### rtl/btre_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// btre_pkg
// Types and codes shared by the beacon tree route engine.
// ----------------------------------------------------------------------------
package btre_pkg;

  localparam logic [1:0] KIND_SEND = 2'd0;
  localparam logic [1:0] KIND_RECV = 2'd1;
  localparam logic [1:0] KIND_DIST = 2'd2;

  localparam logic [1:0] PT_BEACON = 2'd0;
  localparam logic [1:0] PT_DATA   = 2'd1;

  localparam logic [1:0] ACT_DROP     = 2'd0;
  localparam logic [1:0] ACT_TRANSMIT = 2'd1;
  localparam logic [1:0] ACT_DELIVER  = 2'd2;

  localparam logic [7:0] LOST_GAP  = 8'd5;
  localparam logic [7:0] BASE_ADDR = 8'd0;
  localparam logic [7:0] NODE_ID_RESET = 8'hFF;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] hdr_type;
    logic [7:0] src;
    logic [7:0] dest;
    logic [7:0] prev_addr;
    logic [7:0] fwd_addr;
    logic [7:0] seqno;
    logic [7:0] ttl;
    logic [7:0] pkt_distance;
    logic [7:0] new_distance;
  } req_t;

  typedef struct packed {
    logic [1:0] action;
    logic [1:0] out_type;
    logic [7:0] out_src;
    logic [7:0] out_dest;
    logic [7:0] out_prev_addr;
    logic [7:0] out_fwd_addr;
    logic [7:0] out_seqno;
    logic [7:0] out_ttl;
    logic [7:0] out_pkt_distance;
    logic [7:0] out_sender_distance;
    logic [7:0] my_distance;
    logic [7:0] parent_id;
  } res_t;

endpackage
`default_nettype wire

### rtl/beacon_tree_route_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// beacon_tree_route_engine
// Routing header engine for a node of a base-station tree: builds, filters,
// forwards and delivers headers around a source-to-last-hop route table.
//
// channel   direction  handshake                 payload
// request   in         start_i, busy_o           kind_i .. new_distance_i
// result    out        done_o (one-cycle strobe)  action_o .. parent_id_o
// config    in         cfg_valid_i, cfg_ready_o  cfg_data_i (node_id)
//
// Each request runs in order: the route table read at accept, then the
// read-modify-write cycle in ST_EXEC; done_o pulses the cycle after, while
// the next request may already be accepted. Reset clears the table through
// per-entry valid bits, with no sweep. The result side cannot stall; results
// are never held back.
// ----------------------------------------------------------------------------
module beacon_tree_route_engine
  import btre_pkg::*;
#(
  parameter int TABLE_ENTRIES = 256,
  parameter int MAX_HOPS      = 20
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  output logic            busy_o,
  input  wire logic [1:0] kind_i,
  input  wire logic [1:0] hdr_type_i,
  input  wire logic [7:0] src_i,
  input  wire logic [7:0] dest_i,
  input  wire logic [7:0] prev_addr_i,
  input  wire logic [7:0] fwd_addr_i,
  input  wire logic [7:0] seqno_i,
  input  wire logic [7:0] ttl_i,
  input  wire logic [7:0] pkt_distance_i,
  input  wire logic [7:0] new_distance_i,
  output logic            done_o,
  output logic [1:0]      action_o,
  output logic [1:0]      out_type_o,
  output logic [7:0]      out_src_o,
  output logic [7:0]      out_dest_o,
  output logic [7:0]      out_prev_addr_o,
  output logic [7:0]      out_fwd_addr_o,
  output logic [7:0]      out_seqno_o,
  output logic [7:0]      out_ttl_o,
  output logic [7:0]      out_pkt_distance_o,
  output logic [7:0]      out_sender_distance_o,
  output logic [7:0]      my_distance_o,
  output logic [7:0]      parent_id_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [7:0] cfg_data_i
);

  localparam int         IdxW    = $clog2(TABLE_ENTRIES);
  localparam logic [8:0] Entries = 9'(TABLE_ENTRIES);
  localparam logic [7:0] MaxHops = 8'(MAX_HOPS);

  state_e state_q, state_d;
  req_t   req_q;
  res_t   res_q, res_d;
  logic   done_q;

  logic [7:0] node_id_q;
  logic [7:0] hop_q, hop_d;
  logic [7:0] data_seq_q, data_seq_d;
  logic [7:0] beacon_seq_q, beacon_seq_d;
  logic [7:0] last_fwd_q, last_fwd_d;
  logic [7:0] parent_q, parent_d;

  logic [7:0]               mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_q;
  logic [7:0]               rd_data_q;
  logic                     rd_hit_q;

  logic       accept;
  logic [7:0] rd_addr;
  logic       rd_in_range;
  logic       wr_en;
  logic       wr_in_range;
  logic [7:0] tbl_val;
  logic       keep;
  logic       lost;
  logic       better;
  logic [8:0] pdist_inc;
  logic [7:0] hop_mid;

  assign accept      = start_i && !busy_o;
  assign cfg_ready_o = 1'b1;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_EXEC;
      ST_EXEC: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    unique case (state_q)
      ST_EXEC: busy_o = 1'b1;
      default: busy_o = 1'b0;
    endcase
  end

  always_comb begin
    if (kind_i == KIND_RECV && hdr_type_i == PT_BEACON) begin
      rd_addr = src_i;
    end else begin
      rd_addr = dest_i;
    end
  end
  assign rd_in_range = {1'b0, rd_addr} < Entries;
  assign wr_in_range = {1'b0, req_q.src} < Entries;

  assign tbl_val   = rd_hit_q ? rd_data_q : 8'd0;
  assign pdist_inc = {1'b0, req_q.pkt_distance} + 9'd1;

  always_comb begin
    keep = 1'b1;
    priority if (req_q.src == node_id_q) begin
      keep = 1'b0;
    end else if (req_q.seqno == last_fwd_q && hop_q != MaxHops) begin
      keep = 1'b0;
    end else if (req_q.ttl <= 8'd1 || req_q.ttl > MaxHops) begin
      keep = 1'b0;
    end else begin
      keep = 1'b1;
    end
  end

  assign lost = (req_q.seqno > LOST_GAP) && ((req_q.seqno - LOST_GAP) > last_fwd_q)
                && (node_id_q != BASE_ADDR);
  assign hop_mid = lost ? MaxHops : hop_q;
  assign better  = pdist_inc < {1'b0, hop_mid};

  always_comb begin
    res_d        = '0;
    hop_d        = hop_q;
    data_seq_d   = data_seq_q;
    beacon_seq_d = beacon_seq_q;
    last_fwd_d   = last_fwd_q;
    wr_en        = 1'b0;
    priority if (req_q.kind == KIND_SEND) begin
      res_d.action              = ACT_TRANSMIT;
      res_d.out_type            = req_q.hdr_type;
      res_d.out_src             = node_id_q;
      res_d.out_dest            = req_q.dest;
      res_d.out_prev_addr       = node_id_q;
      res_d.out_fwd_addr        = tbl_val;
      res_d.out_ttl             = MaxHops;
      res_d.out_pkt_distance    = hop_q;
      res_d.out_sender_distance = hop_q;
      if (req_q.hdr_type == PT_BEACON) begin
        res_d.out_seqno = beacon_seq_q;
        beacon_seq_d    = beacon_seq_q + 8'd1;
      end else begin
        res_d.out_seqno = data_seq_q;
        data_seq_d      = data_seq_q + 8'd1;
      end
    end else if (req_q.kind == KIND_RECV && req_q.hdr_type == PT_BEACON) begin
      if (keep) begin
        hop_d = hop_mid;
        if (better || req_q.prev_addr == tbl_val) begin
          wr_en      = 1'b1;
          last_fwd_d = req_q.seqno;
          if (better && node_id_q != BASE_ADDR && req_q.src == BASE_ADDR) begin
            hop_d = pdist_inc[7:0];
          end
          res_d.action           = ACT_TRANSMIT;
          res_d.out_type         = req_q.hdr_type;
          res_d.out_src          = req_q.src;
          res_d.out_dest         = req_q.dest;
          res_d.out_prev_addr    = node_id_q;
          res_d.out_fwd_addr     = req_q.fwd_addr;
          res_d.out_seqno        = req_q.seqno;
          res_d.out_ttl          = req_q.ttl - 8'd1;
          res_d.out_pkt_distance = hop_d;
        end
      end
    end else if (req_q.kind == KIND_RECV && req_q.hdr_type == PT_DATA) begin
      if (req_q.dest == node_id_q) begin
        wr_en                  = 1'b1;
        res_d.action           = ACT_DELIVER;
        res_d.out_type         = req_q.hdr_type;
        res_d.out_src          = req_q.src;
        res_d.out_dest         = req_q.dest;
        res_d.out_prev_addr    = req_q.prev_addr;
        res_d.out_fwd_addr     = req_q.fwd_addr;
        res_d.out_seqno        = req_q.seqno;
        res_d.out_ttl          = req_q.ttl;
        res_d.out_pkt_distance = req_q.pkt_distance;
      end else if (req_q.ttl != 8'd1 && req_q.fwd_addr == node_id_q) begin
        wr_en               = 1'b1;
        res_d.action        = ACT_TRANSMIT;
        res_d.out_type      = req_q.hdr_type;
        res_d.out_src       = req_q.src;
        res_d.out_dest      = req_q.dest;
        res_d.out_prev_addr = node_id_q;
        // lookup sees the write of this same request when src equals dest
        if (req_q.src == req_q.dest && wr_in_range) begin
          res_d.out_fwd_addr = req_q.prev_addr;
        end else begin
          res_d.out_fwd_addr = tbl_val;
        end
        res_d.out_seqno        = req_q.seqno;
        res_d.out_ttl          = req_q.ttl - 8'd1;
        res_d.out_pkt_distance = req_q.pkt_distance - 8'd1;
      end
    end else if (req_q.kind == KIND_DIST) begin
      hop_d = req_q.new_distance;
    end else begin
      hop_d = hop_q;
    end
    parent_d = parent_q;
    if (wr_en && req_q.src == BASE_ADDR) begin
      parent_d = req_q.prev_addr;
    end
    res_d.my_distance = hop_d;
    res_d.parent_id   = parent_d;
  end

  // route table
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_data_q <= mem[rd_addr[IdxW-1:0]];
    end
    if (state_q == ST_EXEC && wr_en && wr_in_range) begin
      mem[req_q.src[IdxW-1:0]] <= req_q.prev_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_hit_q <= 1'b0;
    end else begin
      if (accept) begin
        rd_hit_q <= rd_in_range && valid_q[rd_addr[IdxW-1:0]];
      end
      if (state_q == ST_EXEC && wr_en && wr_in_range) begin
        valid_q[req_q.src[IdxW-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      done_q       <= 1'b0;
      node_id_q    <= NODE_ID_RESET;
      hop_q        <= MaxHops;
      data_seq_q   <= '0;
      beacon_seq_q <= '0;
      last_fwd_q   <= '0;
      parent_q     <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == ST_EXEC);
      if (cfg_valid_i && cfg_ready_o) begin
        node_id_q <= cfg_data_i;
      end
      if (state_q == ST_EXEC) begin
        hop_q        <= hop_d;
        data_seq_q   <= data_seq_d;
        beacon_seq_q <= beacon_seq_d;
        last_fwd_q   <= last_fwd_d;
        parent_q     <= parent_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q.kind         <= kind_i;
      req_q.hdr_type     <= hdr_type_i;
      req_q.src          <= src_i;
      req_q.dest         <= dest_i;
      req_q.prev_addr    <= prev_addr_i;
      req_q.fwd_addr     <= fwd_addr_i;
      req_q.seqno        <= seqno_i;
      req_q.ttl          <= ttl_i;
      req_q.pkt_distance <= pkt_distance_i;
      req_q.new_distance <= new_distance_i;
    end
    if (state_q == ST_EXEC) begin
      res_q <= res_d;
    end
  end

  assign done_o                = done_q;
  assign action_o              = res_q.action;
  assign out_type_o            = res_q.out_type;
  assign out_src_o             = res_q.out_src;
  assign out_dest_o            = res_q.out_dest;
  assign out_prev_addr_o       = res_q.out_prev_addr;
  assign out_fwd_addr_o        = res_q.out_fwd_addr;
  assign out_seqno_o           = res_q.out_seqno;
  assign out_ttl_o             = res_q.out_ttl;
  assign out_pkt_distance_o    = res_q.out_pkt_distance;
  assign out_sender_distance_o = res_q.out_sender_distance;
  assign my_distance_o         = res_q.my_distance;
  assign parent_id_o           = res_q.parent_id;

`ifndef ASSERT_OFF
  a_accept_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o ##1 (done_o && !busy_o))
    else $error("request did not complete in two cycles");

  a_fwd_only_on_beacon: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(last_fwd_q) |-> (done_o && action_o == ACT_TRANSMIT
                              && out_type_o == PT_BEACON))
    else $error("last forwarded beacon changed without a beacon forward");

  a_dist_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (my_distance_o == hop_q && parent_id_o == parent_q))
    else $error("reported distance or parent differs from state");
`endif

endmodule
`default_nettype wire
